@@ hdl/ccns_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ccns_pkg
// Shared widths and constants for the cycle-count to nanosecond converter.
// ---------------------------------------------------------------------------
package ccns_pkg;

  localparam int unsigned CLK_W  = 32;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned NS_W   = 30;
  localparam int unsigned PROD_W = TIME_W + NS_W;

  localparam logic [NS_W-1:0]  NS_PER_SEC  = 30'd1000000000;
  localparam logic [CLK_W-1:0] CLOCK_RESET = 32'd168000000;

endpackage : ccns_pkg
`default_nettype wire

@@ hdl/ccns_div.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ccns_div
// Restoring divider, two quotient bits per cycle, dividend shifted through
// one register that collects the quotient. Returns the low TIME_W bits.
// ---------------------------------------------------------------------------
module ccns_div
  import ccns_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [CLK_W-1:0]  divisor,
  output logic                   done,
  output logic [TIME_W-1:0]      quotient
);

  localparam int unsigned STEPS = PROD_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic [PROD_W-1:0] dq_r, dq_nxt;
  logic [CLK_W-1:0]  rem_r, rem_nxt;
  logic [CLK_W-1:0]  div_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [CLK_W:0]    r_a, r_b;
  logic              ge_a, ge_b;
  logic [CLK_W-1:0]  rem_a;

  always_comb begin
    r_a     = {rem_r, dq_r[PROD_W-1]};
    ge_a    = r_a >= {1'b0, div_r};
    rem_a   = ge_a ? CLK_W'(r_a - {1'b0, div_r}) : r_a[CLK_W-1:0];
    r_b     = {rem_a, dq_r[PROD_W-2]};
    ge_b    = r_b >= {1'b0, div_r};
    rem_nxt = ge_b ? CLK_W'(r_b - {1'b0, div_r}) : r_b[CLK_W-1:0];
    dq_nxt  = {dq_r[PROD_W-3:0], ge_a, ge_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        dq_r   <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
        cnt_r  <= CNT_W'(STEPS - 1);
      end else if (busy_r) begin
        dq_r  <= dq_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dq_r[TIME_W-1:0];

endmodule : ccns_div
`default_nettype wire

@@ hdl/cycle_count_to_nanoseconds_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cycle_count_to_nanoseconds_top
// Extends a free-running cycle counter to a 64-bit cycle total and converts
// it to nanoseconds: floor(total * 1e9 / core_clock_hz) modulo 2^64.
// ---------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | tdata[31:0] cycle_sample
//  out_    | master    | tdata[63:0] time_ns
//  cfg_    | write     | data[31:0]  core_clock_hz
//
//  Each transaction steps through the accept, the bit-serial multiply by 1e9,
//  the two-bit-per-cycle divide of the 94-bit product and the load of the
//  output register. The next transaction is taken while a result still waits
//  on out_. Reset clears the cycle total, the previous sample and sets the
//  clock register to 168 MHz.
// ---------------------------------------------------------------------------
module cycle_count_to_nanoseconds_top
  import ccns_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [31:0]       in_tdata,   // [31:0] cycle_sample
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [TIME_W-1:0]      out_tdata,  // [63:0] time_ns
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CLK_W-1:0]  cfg_data    // [31:0] core_clock_hz
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} state_t;

  localparam int unsigned NCNT_W = $clog2(NS_W);

  state_t                  state_r;
  logic [CLK_W-1:0]        clk_hz_r;
  logic [SAMPLE_WIDTH-1:0] prev_r;
  logic [TIME_W-1:0]       elapsed_r;
  logic [PROD_W-1:0]       acc_r, acc_nxt;
  logic [NCNT_W-1:0]       cnt_r;
  logic                    out_tvalid_r;
  logic [TIME_W-1:0]       out_tdata_r;

  logic                    in_acc;
  logic                    out_free;
  logic [SAMPLE_WIDTH-1:0] delta;
  logic [CLK_W-1:0]        divisor;
  logic                    div_start;
  logic                    div_done;
  logic [TIME_W-1:0]       div_q;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign delta     = in_tdata[SAMPLE_WIDTH-1:0] - prev_r;
  assign divisor   = (clk_hz_r == '0) ? CLK_W'(1) : clk_hz_r;
  assign acc_nxt   = {acc_r[PROD_W-2:0], 1'b0}
                   + (NS_PER_SEC[cnt_r] ? {{NS_W{1'b0}}, elapsed_r} : '0);
  assign div_start = (state_r == S_MUL) && (cnt_r == '0);

  ccns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_nxt),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      clk_hz_r     <= CLOCK_RESET;
      prev_r       <= '0;
      elapsed_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        clk_hz_r <= cfg_data;
      end
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            prev_r    <= in_tdata[SAMPLE_WIDTH-1:0];
            elapsed_r <= elapsed_r + {{(TIME_W-SAMPLE_WIDTH){1'b0}}, delta};
            acc_r     <= '0;
            cnt_r     <= NCNT_W'(NS_W - 1);
            state_r   <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= div_q;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide phase");

  a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_MUL))
    else $error("accepted transaction did not start multiply");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_tvalid_r) |=> (out_tvalid_r && state_r == S_IDLE))
    else $error("result not loaded into free output register");

endmodule : cycle_count_to_nanoseconds_top
`default_nettype wire
